// File: design/ipz_pkg.sv
// ----------------------------------------------------------------------------
// ipz_pkg
// shared types and constants of the idle page zeroing sequencer
// ----------------------------------------------------------------------------
package ipz_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int RUN_BYTES_DEF  = 32;

    localparam int PAGE_W   = 24;
    localparam int COUNT_W  = 24;
    localparam int BUDGET_W = 13;
    localparam int WOFS_W   = 12;
    localparam int TOTAL_W  = 32;
    localparam int PPS_W    = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 104;

    localparam logic [PPS_W-1:0] PPS_RESET = 16'd20000;
    localparam int BUDGET_DIV = 10;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(20000 / BUDGET_DIV);

    // reciprocal of ten, exact for every 16-bit operand
    localparam logic [PPS_W-1:0] RECIP10   = 16'd52429;
    localparam int               RECIP10_SH = 19;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PPS         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONTEMPORAL = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LOW    = 4'd3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_GET     = 2'd1,
        PH_ZERO    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef struct packed {
        logic                enable;
        logic                nontemporal;
        logic                hold_low;
        logic [BUDGET_W-1:0] budget_load;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] zeroed_pages;
        logic [COUNT_W-1:0] free_pages;
        logic               lock_granted;
        logic               page_offered;
        logic [PAGE_W-1:0]  offered_page;
        logic               resched_request;
    } item_t;

    typedef struct packed {
        phase_t             phase;
        logic               write_valid;
        logic [PAGE_W-1:0]  write_page;
        logic [WOFS_W-1:0]  write_offset;
        logic               write_nontemporal;
        logic               release_valid;
        logic [PAGE_W-1:0]  release_page;
        logic [TOTAL_W-1:0] pages_zeroed_total;
    } result_t;

endpackage

// File: design/ipz_cfg.sv
// ----------------------------------------------------------------------------
// ipz_cfg
// configuration registers, burst budget worked out when the rate is written
// ----------------------------------------------------------------------------
module ipz_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipz_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipz_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ipz_pkg::cfg_t                   cfg
);

    ipz_pkg::cfg_t cfg_reg;
    ipz_pkg::cfg_t cfg_next;
    logic [2*ipz_pkg::PPS_W-1:0] recip_prod;

    assign cfg_ready  = 1'b1;
    // pages_per_second / 10 by reciprocal multiply
    assign recip_prod = (2*ipz_pkg::PPS_W)'(cfg_data) *
                        (2*ipz_pkg::PPS_W)'(ipz_pkg::RECIP10);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ipz_pkg::REG_ENABLE:      cfg_next.enable      = cfg_data[0];
                ipz_pkg::REG_NONTEMPORAL: cfg_next.nontemporal = cfg_data[0];
                ipz_pkg::REG_HOLD_LOW:    cfg_next.hold_low    = cfg_data[0];
                ipz_pkg::REG_PPS:
                    cfg_next.budget_load =
                        recip_prod[ipz_pkg::RECIP10_SH +: ipz_pkg::BUDGET_W];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.nontemporal <= 1'b0;
            cfg_reg.hold_low    <= 1'b0;
            cfg_reg.budget_load <= ipz_pkg::BUDGET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/ipz_in_stage.sv
// ----------------------------------------------------------------------------
// ipz_in_stage
// input register, unpacks the slot fields of one transfer
// ----------------------------------------------------------------------------
module ipz_in_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ipz_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           advance,
    output logic                           item_valid,
    output ipz_pkg::item_t                 item
);

    logic           valid_reg;
    logic           valid_next;
    ipz_pkg::item_t item_reg;
    ipz_pkg::item_t item_next;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        item_next.zeroed_pages    = s_tdata[23:0];
        item_next.free_pages      = s_tdata[47:24];
        item_next.lock_granted    = s_tdata[48];
        item_next.page_offered    = s_tdata[49];
        item_next.offered_page    = s_tdata[73:50];
        item_next.resched_request = s_tdata[74];
        valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/ipz_step.sv
// ----------------------------------------------------------------------------
// ipz_step
// one scheduler slot: next phase, budget, offset and the result item
// ----------------------------------------------------------------------------
module ipz_step
#(
    parameter int PAGE_BYTES = ipz_pkg::PAGE_BYTES_DEF,
    parameter int RUN_BYTES  = ipz_pkg::RUN_BYTES_DEF,
    parameter int OFS_W      = $clog2(PAGE_BYTES + RUN_BYTES)
)
(
    input  ipz_pkg::cfg_t                   cfg,
    input  ipz_pkg::item_t                  item,
    input  ipz_pkg::phase_t                 phase,
    input  logic [ipz_pkg::BUDGET_W-1:0]    budget,
    input  logic [ipz_pkg::PAGE_W-1:0]      held_page,
    input  logic [OFS_W-1:0]                run_offset,
    input  logic [ipz_pkg::TOTAL_W-1:0]     total,
    output ipz_pkg::phase_t                 phase_next,
    output logic [ipz_pkg::BUDGET_W-1:0]    budget_next,
    output logic [ipz_pkg::PAGE_W-1:0]      held_page_next,
    output logic [OFS_W-1:0]                run_offset_next,
    output logic [ipz_pkg::TOTAL_W-1:0]     total_next,
    output ipz_pkg::result_t                result
);

    localparam int CMP_W = ipz_pkg::COUNT_W + 4;
    localparam logic [OFS_W-1:0] RUN_STEP = OFS_W'(RUN_BYTES);
    localparam logic [OFS_W-1:0] PAGE_END = OFS_W'(PAGE_BYTES);

    logic [CMP_W-1:0] free_w;
    logic [CMP_W-1:0] zp1_w;
    logic             below_4_5;
    logic             below_2_3;
    logic             need_zero;
    logic [ipz_pkg::BUDGET_W-1:0] budget_dec;
    logic [OFS_W-1:0] ofs_inc;
    logic [31:0]      ofs_wide;

    // zeroed < floor(a*f/b)  <=>  a*f >= b*(zeroed+1)
    assign free_w    = CMP_W'(item.free_pages);
    assign zp1_w     = CMP_W'(item.zeroed_pages) + CMP_W'(1);
    assign below_4_5 = (free_w << 2) >= ((zp1_w << 2) + zp1_w);
    assign below_2_3 = (free_w << 1) >= ((zp1_w << 1) + zp1_w);
    assign need_zero = cfg.enable && below_4_5 && (!cfg.hold_low || below_2_3);

    assign budget_dec = budget - ipz_pkg::BUDGET_W'(1);
    assign ofs_inc    = run_offset + RUN_STEP;
    assign ofs_wide   = 32'(run_offset);

    always_comb
    begin
        phase_next      = phase;
        budget_next     = budget;
        held_page_next  = held_page;
        run_offset_next = run_offset;
        total_next      = total;
        result          = '0;
        case (phase)
            ipz_pkg::PH_IDLE:
            begin
                if (need_zero)
                begin
                    budget_next = cfg.budget_load;
                end
                if (budget_next != '0)
                begin
                    phase_next = ipz_pkg::PH_GET;
                end
            end
            ipz_pkg::PH_GET:
            begin
                if (!item.lock_granted)
                begin
                    phase_next = ipz_pkg::PH_IDLE;
                end
                else
                begin
                    budget_next = budget_dec;
                    if (budget_dec == '0 || !item.page_offered)
                    begin
                        phase_next = ipz_pkg::PH_IDLE;
                    end
                    else
                    begin
                        held_page_next  = item.offered_page;
                        run_offset_next = '0;
                        phase_next      = ipz_pkg::PH_ZERO;
                    end
                end
            end
            ipz_pkg::PH_ZERO:
            begin
                if (!item.resched_request)
                begin
                    result.write_valid       = 1'b1;
                    result.write_page        = held_page;
                    result.write_offset      = ofs_wide[ipz_pkg::WOFS_W-1:0];
                    result.write_nontemporal = cfg.nontemporal;
                    run_offset_next          = ofs_inc;
                    if (ofs_inc >= PAGE_END)
                    begin
                        phase_next = ipz_pkg::PH_RELEASE;
                    end
                end
            end
            ipz_pkg::PH_RELEASE:
            begin
                if (item.lock_granted)
                begin
                    result.release_valid = 1'b1;
                    result.release_page  = held_page;
                    total_next           = total + ipz_pkg::TOTAL_W'(1);
                    phase_next           = ipz_pkg::PH_GET;
                end
            end
            default: ;
        endcase
        result.phase              = phase_next;
        result.pages_zeroed_total = total_next;
    end

endmodule

// File: design/idle_page_zeroing_sequencer.sv
// ----------------------------------------------------------------------------
// idle_page_zeroing_sequencer
// background page zeroing sequencer driven by one scheduler slot per transfer
// ----------------------------------------------------------------------------
// Each input transfer is one scheduler slot and yields exactly one output
// transfer. A slot is taken into an input register, worked through the
// combinational phase logic and written to the output register, so one
// slot is taken every clock cycle while the output side keeps up; the
// result passes through the input and the output register and, with the
// output side ready, transfers from there. The rate is set by the phase
// and counter state, which is updated once per slot. The input side can
// still take one slot into its register while a result waits in the
// output register, and stalls only when both registers are full.
// Configuration writes complete in the cycle they are presented; the
// burst budget (rate / 10) is worked out when the rate register is written.
// ----------------------------------------------------------------------------
module idle_page_zeroing_sequencer
#(
    parameter int PAGE_BYTES = ipz_pkg::PAGE_BYTES_DEF,
    parameter int RUN_BYTES  = ipz_pkg::RUN_BYTES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ipz_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipz_pkg::CFG_DATA_W-1:0]  cfg_data,
    // slot input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // zeroed_pages[23:0], free_pages[47:24], lock_granted[48],
    // page_offered[49], offered_page[73:50], resched_request[74], zero fill
    input  logic [ipz_pkg::IN_DATA_W-1:0]   s_tdata,
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // phase[1:0], write_valid[2], write_page[26:3], write_offset[38:27],
    // write_nontemporal[39], release_valid[40], release_page[64:41],
    // pages_zeroed_total[96:65], zero fill
    output logic [ipz_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // offset register holds up to the first value at or past the page end
    localparam int OFS_W = $clog2(PAGE_BYTES + RUN_BYTES);

    ipz_pkg::cfg_t    cfg;
    ipz_pkg::item_t   item;
    logic             item_valid;
    logic             advance;

    // sequencer state
    ipz_pkg::phase_t              phase_reg;
    ipz_pkg::phase_t              phase_next;
    logic [ipz_pkg::BUDGET_W-1:0] budget_reg;
    logic [ipz_pkg::BUDGET_W-1:0] budget_next;
    logic [ipz_pkg::PAGE_W-1:0]   held_page_reg;
    logic [ipz_pkg::PAGE_W-1:0]   held_page_next;
    logic [OFS_W-1:0]             run_offset_reg;
    logic [OFS_W-1:0]             run_offset_next;
    logic [ipz_pkg::TOTAL_W-1:0]  total_reg;
    logic [ipz_pkg::TOTAL_W-1:0]  total_next;

    // output register
    ipz_pkg::result_t result_next;
    ipz_pkg::result_t result_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    ipz_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipz_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ipz_step
    #(
        .PAGE_BYTES (PAGE_BYTES),
        .RUN_BYTES  (RUN_BYTES),
        .OFS_W      (OFS_W)
    )
    u_step
    (
        .cfg             (cfg),
        .item            (item),
        .phase           (phase_reg),
        .budget          (budget_reg),
        .held_page       (held_page_reg),
        .run_offset      (run_offset_reg),
        .total           (total_reg),
        .phase_next      (phase_next),
        .budget_next     (budget_next),
        .held_page_next  (held_page_next),
        .run_offset_next (run_offset_next),
        .total_next      (total_next),
        .result          (result_next)
    );

    // a slot moves on when the output register is free or being emptied
    assign advance        = item_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ipz_pkg::PH_IDLE;
            budget_reg     <= '0;
            held_page_reg  <= '0;
            run_offset_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg      <= phase_next;
                budget_reg     <= budget_next;
                held_page_reg  <= held_page_next;
                run_offset_reg <= run_offset_next;
                total_reg      <= total_next;
            end
        end
    end

    // result payload, loaded only when a slot completes
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       result_reg.pages_zeroed_total,
                       result_reg.release_page,
                       result_reg.release_valid,
                       result_reg.write_nontemporal,
                       result_reg.write_offset,
                       result_reg.write_page,
                       result_reg.write_valid,
                       result_reg.phase};

    // a page is only held while the budget still has pages left
    a_budget_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ipz_pkg::PH_ZERO || phase_reg == ipz_pkg::PH_RELEASE)
            |-> (budget_reg != '0))
        else $error("page held with an empty budget");

    // a zero run is only written from the zero phase
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.write_valid)
            |-> (result_reg.phase == ipz_pkg::PH_ZERO ||
                 result_reg.phase == ipz_pkg::PH_RELEASE))
        else $error("zero run outside the zero phase");

    // a release always hands back to the get phase and never writes
    a_release_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.release_valid)
            |-> (result_reg.phase == ipz_pkg::PH_GET && !result_reg.write_valid))
        else $error("release with wrong phase or a write");

    // the zeroed page count moves only by one release per completed slot
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (total_reg == $past(total_reg) + ipz_pkg::TOTAL_W'(1)) ==
                    $past(result_next.release_valid))
        else $error("zeroed page count out of step with releases");

endmodule

// File: test/idle_page_zeroing_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_page_zeroing_sequencer_test
// self-checking bench for the background page zeroing sequencer
// ----------------------------------------------------------------------------
// Scheduler slots are queued by the stimulus process and handed to the block
// by a clocked driver. The driver carries its own copy of the sequencer
// phases, budget, held page and counters, and works out the expected result
// of every slot at the moment the slot transfer is taken. A clocked monitor
// compares each result transfer, field by field, with the oldest expected
// result. Both sides may idle in random bursts. The rate and mode registers
// are changed between phases, once every expected result has come back.
// ----------------------------------------------------------------------------
module idle_page_zeroing_sequencer_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    // fractions of the free count used by the zeroing check
    localparam int HOLD_NUM  = 2;
    localparam int HOLD_DEN  = 3;
    localparam int LIMIT_NUM = 4;
    localparam int LIMIT_DEN = 5;

    localparam logic [ipz_pkg::PAGE_W-1:0] PAGE_MAX = '1;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [ipz_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ipz_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [ipz_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [ipz_pkg::OUT_DATA_W-1:0] m_tdata;

    idle_page_zeroing_sequencer u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // register copy, as last written over the configuration channel
    logic                      zero_enable = 1'b0;
    logic [ipz_pkg::PPS_W-1:0] zero_rate   = ipz_pkg::PPS_RESET;
    logic                      zero_nt     = 1'b0;
    logic                      zero_hold   = 1'b0;

    // sequencer state as the bench sees it
    ipz_pkg::phase_t              seq_phase  = ipz_pkg::PH_IDLE;
    logic [ipz_pkg::BUDGET_W-1:0] seq_budget = '0;
    logic [ipz_pkg::PAGE_W-1:0]   seq_page   = '0;
    logic [12:0]                  seq_offset = '0;
    logic [ipz_pkg::TOTAL_W-1:0]  seq_total  = '0;

    ipz_pkg::item_t   slot_backlog[$];      // slots waiting for the driver
    ipz_pkg::result_t awaited_results[$];   // expected results, oldest first
    ipz_pkg::item_t   slot_on_bus;

    int slots_queued   = 0;
    int slots_taken    = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    // --------------------------------------------------------------------
    // prediction
    // --------------------------------------------------------------------

    // zeroing is wanted while the zeroed count is under the active fraction
    function automatic logic zeroing_wanted(logic [ipz_pkg::COUNT_W-1:0] zeroed,
                                            logic [ipz_pkg::COUNT_W-1:0] free_cnt);
        logic [47:0] hold_mark;
        logic [47:0] limit_mark;
        hold_mark  = (48'(free_cnt) * HOLD_NUM) / HOLD_DEN;
        limit_mark = (48'(free_cnt) * LIMIT_NUM) / LIMIT_DEN;
        if (!zero_enable)
            return 1'b0;
        if (zero_hold && 48'(zeroed) >= hold_mark)
            return 1'b0;
        if (48'(zeroed) >= limit_mark)
            return 1'b0;
        return 1'b1;
    endfunction

    // one scheduler slot: advance the bench state, return the slot's result
    function automatic ipz_pkg::result_t next_slot_result(ipz_pkg::item_t slot);
        ipz_pkg::result_t r;
        r = '0;
        case (seq_phase)
            ipz_pkg::PH_IDLE:
            begin
                // a failed check keeps any budget left from an aborted burst
                if (zeroing_wanted(slot.zeroed_pages, slot.free_pages))
                    seq_budget = ipz_pkg::BUDGET_W'(zero_rate / ipz_pkg::BUDGET_DIV);
                if (seq_budget != '0)
                    seq_phase = ipz_pkg::PH_GET;
            end
            ipz_pkg::PH_GET:
            begin
                if (!slot.lock_granted)
                    seq_phase = ipz_pkg::PH_IDLE;
                else
                begin
                    seq_budget = seq_budget - 1'b1;
                    if (seq_budget == '0 || !slot.page_offered)
                        seq_phase = ipz_pkg::PH_IDLE;
                    else
                    begin
                        seq_page   = slot.offered_page;
                        seq_offset = '0;
                        seq_phase  = ipz_pkg::PH_ZERO;
                    end
                end
            end
            ipz_pkg::PH_ZERO:
            begin
                // a yield writes nothing and keeps the phase
                if (!slot.resched_request)
                begin
                    r.write_valid       = 1'b1;
                    r.write_page        = seq_page;
                    r.write_offset      = seq_offset[ipz_pkg::WOFS_W-1:0];
                    r.write_nontemporal = zero_nt;
                    seq_offset          = seq_offset + 13'(ipz_pkg::RUN_BYTES_DEF);
                    if (seq_offset >= 13'(ipz_pkg::PAGE_BYTES_DEF))
                        seq_phase = ipz_pkg::PH_RELEASE;
                end
            end
            default:
            begin
                // release waits here until the lock is granted
                if (slot.lock_granted)
                begin
                    r.release_valid = 1'b1;
                    r.release_page  = seq_page;
                    seq_total       = seq_total + 1'b1;
                    seq_phase       = ipz_pkg::PH_GET;
                end
            end
        endcase
        r.phase              = seq_phase;
        r.pages_zeroed_total = seq_total;
        return r;
    endfunction

    // --------------------------------------------------------------------
    // packing of the stream words, lowest field in the lowest bits
    // --------------------------------------------------------------------

    function automatic logic [ipz_pkg::IN_DATA_W-1:0] pack_slot(ipz_pkg::item_t slot);
        return ipz_pkg::IN_DATA_W'({slot.resched_request, slot.offered_page,
                                    slot.page_offered, slot.lock_granted,
                                    slot.free_pages, slot.zeroed_pages});
    endfunction

    function automatic ipz_pkg::result_t unpack_result(
        logic [ipz_pkg::OUT_DATA_W-1:0] d);
        ipz_pkg::result_t r;
        r.phase              = ipz_pkg::phase_t'(d[1:0]);
        r.write_valid        = d[2];
        r.write_page         = d[26:3];
        r.write_offset       = d[38:27];
        r.write_nontemporal  = d[39];
        r.release_valid      = d[40];
        r.release_page       = d[64:41];
        r.pages_zeroed_total = d[96:65];
        return r;
    endfunction

    function automatic ipz_pkg::item_t make_slot(logic [ipz_pkg::COUNT_W-1:0] zeroed,
                                                 logic [ipz_pkg::COUNT_W-1:0] free_cnt,
                                                 logic lock, logic offered,
                                                 logic [ipz_pkg::PAGE_W-1:0] page,
                                                 logic resched);
        ipz_pkg::item_t s;
        s.zeroed_pages    = zeroed;
        s.free_pages      = free_cnt;
        s.lock_granted    = lock;
        s.page_offered    = offered;
        s.offered_page    = page;
        s.resched_request = resched;
        return s;
    endfunction

    // mostly slots that let a burst run, with counts around the thresholds
    function automatic ipz_pkg::item_t random_slot();
        ipz_pkg::item_t s;
        int             pick;
        pick = $urandom_range(99);
        if (pick < 8)
            s.free_pages = '0;
        else if (pick < 16)
            s.free_pages = PAGE_MAX;
        else if (pick < 50)
            s.free_pages = ipz_pkg::COUNT_W'($urandom_range(1, 200));
        else
            s.free_pages = ipz_pkg::COUNT_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            s.zeroed_pages = ipz_pkg::COUNT_W'($urandom_range(0, int'(s.free_pages) / 2));
        else if (pick < 80)
            s.zeroed_pages = ipz_pkg::COUNT_W'((48'(s.free_pages) * HOLD_NUM) / HOLD_DEN);
        else if (pick < 90)
            s.zeroed_pages = ipz_pkg::COUNT_W'((48'(s.free_pages) * LIMIT_NUM) / LIMIT_DEN);
        else
            s.zeroed_pages = ipz_pkg::COUNT_W'($urandom);
        s.lock_granted    = ($urandom_range(99) < 85);
        s.page_offered    = ($urandom_range(99) < 85);
        s.offered_page    = ipz_pkg::PAGE_W'($urandom);
        s.resched_request = ($urandom_range(99) < 15);
        return s;
    endfunction

    // --------------------------------------------------------------------
    // checking
    // --------------------------------------------------------------------

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d: %s expected %0h, got %0h",
                         results_seen, name, want, got);
        end
    endtask

    task automatic check_result(ipz_pkg::result_t got);
        ipz_pkg::result_t want;
        if (awaited_results.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("result %0d: transfer with no expected result, data %h",
                         results_seen, m_tdata);
        end
        else
        begin
            want = awaited_results.pop_front();
            compare_field("phase", 32'(want.phase), 32'(got.phase));
            compare_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
            compare_field("write_page", 32'(want.write_page), 32'(got.write_page));
            compare_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
            compare_field("write_nontemporal", 32'(want.write_nontemporal),
                          32'(got.write_nontemporal));
            compare_field("release_valid", 32'(want.release_valid), 32'(got.release_valid));
            compare_field("release_page", 32'(want.release_page), 32'(got.release_page));
            compare_field("pages_zeroed_total", want.pages_zeroed_total,
                          got.pages_zeroed_total);
        end
    endtask

    // --------------------------------------------------------------------
    // slot driver: holds a transfer until taken, idles in random bursts
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end
        else
        begin
            // prediction happens at the transfer itself, in slot order
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(next_slot_result(slot_on_bus));
                slots_taken++;
            end
            if (s_tvalid && !s_tready)
            begin
                // transfer still pending, keep it on the bus
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                gap_left = $urandom_range(0, 13);
                s_tvalid <= 1'b0;
            end
            else if (slot_backlog.size() > 0)
            begin
                slot_on_bus = slot_backlog.pop_front();
                s_tdata  <= pack_slot(slot_on_bus);
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // --------------------------------------------------------------------
    // result monitor: checks each transfer, stalls in random bursts
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                check_result(unpack_result(m_tdata));
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // --------------------------------------------------------------------
    // watchdog: too long without any transfer ends the run
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("idle_page_zeroing_sequencer_test: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // --------------------------------------------------------------------
    // stimulus
    // --------------------------------------------------------------------

    task automatic queue_slot(ipz_pkg::item_t slot);
        slot_backlog.push_back(slot);
        slots_queued++;
    endtask

    // every queued slot taken and answered, then a short settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (slots_taken != slots_queued || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [ipz_pkg::CFG_IDX_W-1:0] idx,
                             logic [ipz_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            ipz_pkg::REG_ENABLE:      zero_enable = value[0];
            ipz_pkg::REG_PPS:         zero_rate   = value[ipz_pkg::PPS_W-1:0];
            ipz_pkg::REG_NONTEMPORAL: zero_nt     = value[0];
            ipz_pkg::REG_HOLD_LOW:    zero_hold   = value[0];
            default:                  ;
        endcase
    endtask

    task automatic set_mode(logic en, logic [ipz_pkg::PPS_W-1:0] rate, logic nt,
                            logic hold);
        wait_drained();
        write_reg(ipz_pkg::REG_ENABLE, ipz_pkg::CFG_DATA_W'(en));
        write_reg(ipz_pkg::REG_PPS, rate);
        write_reg(ipz_pkg::REG_NONTEMPORAL, ipz_pkg::CFG_DATA_W'(nt));
        write_reg(ipz_pkg::REG_HOLD_LOW, ipz_pkg::CFG_DATA_W'(hold));
    endtask

    task automatic run_phase(logic en, logic [ipz_pkg::PPS_W-1:0] rate, logic nt,
                             logic hold, int count, bit idling);
        set_mode(en, rate, nt, hold);
        send_idle_pct = idling ? $urandom_range(5, 35) : 0;
        recv_idle_pct = idling ? $urandom_range(5, 35) : 0;
        repeat (count) queue_slot(random_slot());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zeroing disabled, so every slot stays idle
        queue_slot(make_slot('0, PAGE_MAX, 1'b1, 1'b1, PAGE_MAX, 1'b1));
        queue_slot(make_slot(PAGE_MAX, '0, 1'b0, 1'b0, '0, 1'b0));

        // budget of one page, low hold and cache bypass on
        set_mode(1'b1, 16'd15, 1'b1, 1'b1);
        // zeroed exactly at two thirds of free: the low hold stops it
        queue_slot(make_slot(24'd11184810, PAGE_MAX, 1'b0, 1'b0, '0, 1'b0));
        queue_slot(make_slot(24'd11184809, PAGE_MAX, 1'b0, 1'b0, '0, 1'b0));
        // budget runs out on the decrement, no page is taken
        queue_slot(make_slot('0, '0, 1'b1, 1'b1, 24'd1, 1'b0));
        // nothing free: check fails with an empty budget
        queue_slot(make_slot('0, '0, 1'b1, 1'b1, 24'd2, 1'b0));
        queue_slot(make_slot('0, 24'd5, 1'b0, 1'b0, '0, 1'b0));
        // lock refused in get, budget kept
        queue_slot(make_slot('0, '0, 1'b0, 1'b1, 24'd3, 1'b0));
        // failed check but the leftover budget still starts a burst
        queue_slot(make_slot(PAGE_MAX, '0, 1'b0, 1'b0, '0, 1'b0));
        queue_slot(make_slot('0, '0, 1'b1, 1'b1, 24'd4, 1'b0));

        // largest rate, no hold, normal writes
        set_mode(1'b1, '1, 1'b0, 1'b0);
        // just under four fifths of the largest free count
        queue_slot(make_slot(24'd13421771, PAGE_MAX, 1'b0, 1'b0, '0, 1'b0));
        // no page offered after the decrement
        queue_slot(make_slot('0, '0, 1'b1, 1'b0, 24'h123456, 1'b0));
        queue_slot(make_slot(24'd13421772, PAGE_MAX, 1'b0, 1'b0, '0, 1'b0));
        queue_slot(make_slot('0, '0, 1'b1, 1'b1, PAGE_MAX, 1'b0));
        // yield: nothing written, phase stays
        queue_slot(make_slot('0, '0, 1'b0, 1'b0, '0, 1'b1));
        queue_slot(make_slot(PAGE_MAX, PAGE_MAX, 1'b1, 1'b1, PAGE_MAX, 1'b0));
        queue_slot(make_slot('0, '0, 1'b0, 1'b0, '0, 1'b0));
        queue_slot(make_slot('0, '0, 1'b1, 1'b0, 24'h654321, 1'b0));

        // random part, walking through several register settings
        run_phase(1'b1, 16'd20000, 1'b0, 1'b0, 250, 1'b1);
        run_phase(1'b1, 16'hFFFF, 1'b1, 1'b1, 200, 1'b1);
        run_phase(1'b1, 16'd0, 1'b0, 1'b0, 150, 1'b0);
        run_phase(1'b1, 16'd10, 1'b1, 1'b0, 150, 1'b1);
        run_phase(1'b0, 16'd1234, 1'b0, 1'b1, 150, 1'b1);
        run_phase(1'b1, 16'd25, 1'b1, 1'b1, 150, 1'b1);
        run_phase(1'b1, ipz_pkg::PPS_W'($urandom), 1'($urandom), 1'($urandom),
                  250, 1'b1);
        // closing stretch with no idling on either side
        run_phase(1'b1, 16'd30000, 1'b0, 1'b0, 250, 1'b0);

        wait_drained();
        if (error_count == 0)
            $display("idle_page_zeroing_sequencer_test: done, clean");
        else
            $display("idle_page_zeroing_sequencer_test: done, errors");
        $finish;
    end

endmodule
